@@ rtl/tcc_pkg.sv @@
// Shared constants and types of the text console cursor engine.
package tcc_pkg;

  // Default screen geometry and tab width
  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int TAB_STEP_DEF = 8;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Fixed port widths
  localparam int MODE_W = 2;
  localparam int BYTE_W = 8;
  localparam int TCOL_W = 7;
  localparam int TROW_W = 5;
  localparam int POS_W  = 11;
  localparam int CELL_W = 16;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [BYTE_W-1:0] CH_LF        = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;

  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h1F;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  // Classified command
  typedef enum logic [2:0] {
    OP_PRINT     = 3'd0,
    OP_NEWLINE   = 3'd1,
    OP_BACKSPACE = 3'd2,
    OP_TAB       = 3'd3,
    OP_SET       = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_READ      = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT   = 3'd0,
    ST_IDLE   = 3'd1,
    ST_READ   = 3'd2,
    ST_SCROLL = 3'd3,
    ST_FILL   = 3'd4
  } back_state_t;

endpackage

@@ rtl/tcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tcc_front.sv @@
// Front end: accepts input transactions, classifies them and saturates targets.
module tcc_front
  import tcc_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [MODE_W-1:0]          mode,
  input  logic [BYTE_W-1:0]          char_code,
  input  logic [TCOL_W-1:0]          target_col,
  input  logic [TROW_W-1:0]          target_row,
  input  logic                       init_done,
  input  logic                       q_full,
  output logic                       push,
  output op_t                        cmd_op,
  output logic [BYTE_W-1:0]          cmd_char,
  output logic [$clog2(COLUMNS)-1:0] cmd_col,
  output logic [$clog2(ROWS)-1:0]    cmd_row
);

  localparam int CW = $clog2(COLUMNS);
  localparam int RW = $clog2(ROWS);

  assign in_ready = init_done && !q_full;
  assign push     = in_valid && in_ready;
  assign cmd_char = char_code;

  // targets clamp to the last column / row
  always_comb begin
    if (int'(target_col) > COLUMNS - 1) begin
      cmd_col = CW'(COLUMNS - 1);
    end else begin
      cmd_col = CW'(target_col);
    end
    if (int'(target_row) > ROWS - 1) begin
      cmd_row = RW'(ROWS - 1);
    end else begin
      cmd_row = RW'(target_row);
    end
  end

  always_comb begin
    unique case (mode_t'(mode))
      MODE_PUT: begin
        unique case (char_code)
          CH_LF, CH_CR: cmd_op = OP_NEWLINE;
          CH_BACKSPACE: cmd_op = OP_BACKSPACE;
          CH_TAB:       cmd_op = OP_TAB;
          default:      cmd_op = OP_PRINT;
        endcase
      end
      MODE_SET:   cmd_op = OP_SET;
      MODE_CLEAR: cmd_op = OP_CLEAR;
      MODE_READ:  cmd_op = OP_READ;
    endcase
  end

endmodule

@@ rtl/tcc_queue.sv @@
// Short command queue decoupling the front end from the back end.
module tcc_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [NW-1:0]    count;

  assign full  = (count == NW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/tcc_back.sv @@
// Back end: executes commands on the screen store and the cursor, drives results.
module tcc_back
  import tcc_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STEP = TAB_STEP_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [BYTE_W-1:0]          cfg_data,
  input  logic                       cmd_valid,
  output logic                       cmd_pop,
  input  op_t                        cmd_op,
  input  logic [BYTE_W-1:0]          cmd_char,
  input  logic [$clog2(COLUMNS)-1:0] cmd_col,
  input  logic [$clog2(ROWS)-1:0]    cmd_row,
  output logic                       init_done,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [TCOL_W-1:0]          cursor_col,
  output logic [TROW_W-1:0]          cursor_row,
  output logic [POS_W-1:0]           cursor_position,
  output logic [BYTE_W-1:0]          read_char,
  output logic [BYTE_W-1:0]          read_attr
);

  localparam int CW         = $clog2(COLUMNS);
  localparam int RW         = $clog2(ROWS);
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int CXW        = CW + 5;
  localparam int RXW        = RW + 1;
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] MOVE_COUNT = AW'(COLUMNS * (ROWS - 1));

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c,
                                              input logic [RW-1:0] r);
    return AW'(r) * AW'(COLUMNS) + AW'(c);
  endfunction

  back_state_t       state, state_next;
  logic [AW-1:0]     sweep, sweep_next;
  logic              wr_pend, wr_pend_next;
  logic [AW-1:0]     wr_addr, wr_addr_next;
  logic              fill_blank, fill_blank_next;
  logic [CW-1:0]     cur_col, cur_col_next;
  logic [RW-1:0]     cur_row, cur_row_next;
  logic [BYTE_W-1:0] attr;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic              res_load;
  logic [BYTE_W-1:0] res_char;
  logic [BYTE_W-1:0] res_attr;
  logic [AW-1:0]     pos_calc;
  logic              out_free;

  // put-character datapath
  logic [CXW-1:0]    put_colx;
  logic [RXW-1:0]    put_rowx;
  logic [CW-1:0]     put_col;
  logic [RW-1:0]     put_row;
  logic              put_scroll;
  logic              put_we;
  logic [AW-1:0]     put_waddr;
  logic [CELL_W-1:0] put_wdata;
  logic [CW-1:0]     bs_col;

  tcc_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign init_done = (state != ST_INIT);
  assign out_free  = !out_valid || out_ready;
  assign bs_col    = cur_col - 1'b1;

  always_comb begin
    put_colx   = CXW'(cur_col);
    put_rowx   = RXW'(cur_row);
    put_we     = 1'b0;
    put_waddr  = cell_addr(cur_col, cur_row);
    put_wdata  = {attr, cmd_char};
    put_scroll = 1'b0;
    unique case (cmd_op)
      OP_NEWLINE: begin
        put_colx = '0;
        put_rowx = RXW'(cur_row) + 1'b1;
      end
      OP_BACKSPACE: begin
        if (cur_col == '0) begin
          if (cur_row != '0) begin
            put_rowx = RXW'(cur_row) - 1'b1;
            put_colx = CXW'(COLUMNS - 1);
          end
        end else begin
          put_colx  = CXW'(bs_col);
          put_we    = 1'b1;
          put_waddr = cell_addr(bs_col, cur_row);
          put_wdata = {attr, CH_SPACE};
        end
      end
      OP_TAB: begin
        put_colx = CXW'(cur_col) + CXW'(TAB_STEP);
      end
      default: begin
        put_we   = 1'b1;
        put_colx = CXW'(cur_col) + 1'b1;
      end
    endcase
    // line full: wrap to the next row
    if (put_colx > CXW'(COLUMNS - 1)) begin
      put_colx = '0;
      put_rowx = put_rowx + 1'b1;
    end
    // past the last row: stay there and scroll
    if (put_rowx > RXW'(ROWS - 1)) begin
      put_rowx   = RXW'(ROWS - 1);
      put_scroll = 1'b1;
    end
    put_col = put_colx[CW-1:0];
    put_row = put_rowx[RW-1:0];
  end

  always_comb begin
    state_next      = state;
    sweep_next      = sweep;
    wr_pend_next    = 1'b0;
    wr_addr_next    = wr_addr;
    fill_blank_next = fill_blank;
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    ram_we          = 1'b0;
    ram_waddr       = sweep;
    ram_wdata       = '0;
    ram_raddr       = '0;
    cmd_pop         = 1'b0;
    res_load        = 1'b0;
    res_char        = '0;
    res_attr        = '0;
    unique case (state)
      ST_INIT: begin
        ram_we = 1'b1;
        if (sweep == LAST_CELL) begin
          sweep_next = '0;
          state_next = ST_IDLE;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          unique case (cmd_op)
            OP_SET: begin
              cur_col_next = cmd_col;
              cur_row_next = cmd_row;
              res_load     = 1'b1;
            end
            OP_READ: begin
              ram_raddr  = cell_addr(cmd_col, cmd_row);
              state_next = ST_READ;
            end
            OP_CLEAR: begin
              cur_col_next    = '0;
              cur_row_next    = '0;
              fill_blank_next = 1'b1;
              sweep_next      = '0;
              state_next      = ST_FILL;
            end
            OP_PRINT, OP_NEWLINE, OP_BACKSPACE, OP_TAB: begin
              ram_we       = put_we;
              ram_waddr    = put_waddr;
              ram_wdata    = put_wdata;
              cur_col_next = put_col;
              cur_row_next = put_row;
              if (put_scroll) begin
                sweep_next = '0;
                state_next = ST_SCROLL;
              end else begin
                res_load = 1'b1;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        res_load   = 1'b1;
        res_char   = ram_rdata[BYTE_W-1:0];
        res_attr   = ram_rdata[CELL_W-1:BYTE_W];
        state_next = ST_IDLE;
      end
      ST_SCROLL: begin
        // read one row down, write the cell back in the following cycle
        if (sweep != MOVE_COUNT) begin
          ram_raddr    = sweep + AW'(COLUMNS);
          wr_pend_next = 1'b1;
          wr_addr_next = sweep;
          sweep_next   = sweep + 1'b1;
        end
        if (wr_pend) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr;
          ram_wdata = ram_rdata;
        end
        if (sweep == MOVE_COUNT && !wr_pend) begin
          fill_blank_next = 1'b0;
          state_next      = ST_FILL;
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = fill_blank ? {attr, CH_SPACE} : '0;
        if (sweep == LAST_CELL) begin
          sweep_next = '0;
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign pos_calc = cell_addr(cur_col_next, cur_row_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      sweep      <= '0;
      wr_pend    <= 1'b0;
      fill_blank <= 1'b0;
      cur_col    <= '0;
      cur_row    <= '0;
      attr       <= ATTR_RESET;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      sweep      <= sweep_next;
      wr_pend    <= wr_pend_next;
      fill_blank <= fill_blank_next;
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      if (cfg_we) begin
        attr <= cfg_data;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= wr_addr_next;
    if (res_load) begin
      cursor_col      <= TCOL_W'(cur_col_next);
      cursor_row      <= TROW_W'(cur_row_next);
      cursor_position <= POS_W'(pos_calc);
      read_char       <= res_char;
      read_attr       <= res_attr;
    end
  end

endmodule

@@ rtl/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine.
//
// Text console over a COLUMNS x ROWS screen store (16-bit cells: attribute
// in the high byte, character in the low byte) and a cursor. Each input
// transaction is one command: put character, set cursor, clear screen or
// read cell; each gives exactly one result transaction with the cursor
// after the command and, for a read, the addressed cell. After reset the
// block zeroes the screen store and holds in_ready low meanwhile. Put
// character covers printable, newline, tab and backspace codes. Read cell
// passes through a read state, as the RAM read is registered; clear screen
// fills every cell with a blank in the current attribute; a put that
// scrolls moves the screen up a row, one cell per cycle, and then zeroes
// the bottom row. A two-entry command queue sits between the front end and
// the executing back end, so up to two commands are still accepted while a
// result waits in the output register or a sweep is running. The attribute
// register is written through the cfg channel, which is always ready; write
// it only while the engine is idle.
module text_console_cursor_engine
  import tcc_pkg::*;
#(
  parameter int COLUMNS  = COLUMNS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int TAB_STEP = TAB_STEP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration transaction: attribute byte
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] text_attribute,
  // command transaction
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  input  logic [BYTE_W-1:0] char_code,
  input  logic [TCOL_W-1:0] target_col,
  input  logic [TROW_W-1:0] target_row,
  // result transaction
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TCOL_W-1:0] cursor_col,
  output logic [TROW_W-1:0] cursor_row,
  output logic [POS_W-1:0]  cursor_position,
  output logic [BYTE_W-1:0] read_char,
  output logic [BYTE_W-1:0] read_attr
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int OPW   = $bits(op_t);
  localparam int CMD_W = OPW + BYTE_W + CW + RW;

  logic              init_done;
  logic              q_full;
  logic              push;
  op_t               f_op;
  logic [BYTE_W-1:0] f_char;
  logic [CW-1:0]     f_col;
  logic [RW-1:0]     f_row;
  logic [CMD_W-1:0]  q_wdata;
  logic [CMD_W-1:0]  q_rdata;
  logic              q_valid;
  logic              q_pop;

  assign cfg_ready = 1'b1;

  tcc_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .char_code  (char_code),
    .target_col (target_col),
    .target_row (target_row),
    .init_done  (init_done),
    .q_full     (q_full),
    .push       (push),
    .cmd_op     (f_op),
    .cmd_char   (f_char),
    .cmd_col    (f_col),
    .cmd_row    (f_row)
  );

  // command word: {op, char, col, row}
  assign q_wdata = {f_op, f_char, f_col, f_row};

  tcc_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  tcc_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STEP (TAB_STEP)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (text_attribute),
    .cmd_valid       (q_valid),
    .cmd_pop         (q_pop),
    .cmd_op          (op_t'(q_rdata[CMD_W-1 -: OPW])),
    .cmd_char        (q_rdata[CW+RW +: BYTE_W]),
    .cmd_col         (q_rdata[RW +: CW]),
    .cmd_row         (q_rdata[RW-1:0]),
    .init_done       (init_done),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cursor_col      (cursor_col),
    .cursor_row      (cursor_row),
    .cursor_position (cursor_position),
    .read_char       (read_char),
    .read_attr       (read_attr)
  );

endmodule
